@@ rtl/servo_bus_refresh_scheduler_defines.svh @@
// Assertion helpers for the servo bus refresh scheduler
`ifndef SERVO_BUS_REFRESH_SCHEDULER_DEFINES_SVH
`define SERVO_BUS_REFRESH_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define SBRS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define SBRS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SBRS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define SBRS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/sbrs_pkg.sv @@
`default_nettype none

package sbrs_pkg;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_DONE  = 2'd2;

    localparam logic [1:0] REG_SERVO_COUNT    = 2'd0;
    localparam logic [1:0] REG_SERVO_IDS      = 2'd1;
    localparam logic [1:0] REG_MAX_MISSED     = 2'd2;
    localparam logic [1:0] REG_EXPECTED_MODEL = 2'd3;

    localparam logic [2:0] SEND_RAM_READ  = 3'd0;
    localparam logic [2:0] SEND_PING      = 3'd1;
    localparam logic [2:0] SEND_EEPROM    = 3'd2;
    localparam logic [2:0] SEND_TORQUE    = 3'd3;
    localparam logic [2:0] SEND_QUEUED    = 3'd4;

    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_CONNECTED    = 3'd1;
    localparam logic [2:0] EV_DISCONNECTED = 3'd2;
    localparam logic [2:0] EV_RAM_DONE     = 3'd3;
    localparam logic [2:0] EV_ALERT        = 3'd4;

    localparam logic [2:0] ER_NONE        = 3'd0;
    localparam logic [2:0] ER_TICK_OVERLAP = 3'd1;
    localparam logic [2:0] ER_XFER_FAILED = 3'd2;
    localparam logic [2:0] ER_QUEUE_FULL  = 3'd3;
    localparam logic [2:0] ER_HW_ERROR    = 3'd4;
    localparam logic [2:0] ER_ID_MISMATCH = 3'd5;

    localparam logic [2:0] PH_RAM    = 3'd0;
    localparam logic [2:0] PH_PING   = 3'd1;
    localparam logic [2:0] PH_EEPROM = 3'd2;
    localparam logic [2:0] PH_VERIFY = 3'd3;
    localparam logic [2:0] PH_TORQUE = 3'd4;

    localparam logic [7:0] STATUS_ERR_MASK = 8'h7F;
    localparam logic [7:0] STATUS_ALERT    = 8'h80;
    localparam logic [7:0] MISS_MAX        = 8'hFF;

    localparam int MAX_RES = 4;
    localparam int ENTRY_W = 59;

    typedef struct packed {
        logic        send_valid;
        logic [2:0]  send_kind;
        logic [7:0]  send_id;
        logic [15:0] send_address;
        logic [2:0]  send_len;
        logic [31:0] send_data;
        logic [2:0]  event_kind;
        logic [7:0]  event_id;
        logic [2:0]  error_kind;
        logic [7:0]  error_arg;
    } res_t;

    function automatic res_t mk_send(logic [2:0] kind, logic [7:0] id, logic [15:0] addr,
                                     logic [2:0] len, logic [31:0] data);
        res_t r;
        r = '0;
        r.send_valid   = 1'b1;
        r.send_kind    = kind;
        r.send_id      = id;
        r.send_address = addr;
        r.send_len     = len;
        r.send_data    = data;
        return r;
    endfunction

    function automatic res_t mk_event(logic [2:0] kind, logic [7:0] id);
        res_t r;
        r = '0;
        r.event_kind = kind;
        r.event_id   = id;
        return r;
    endfunction

    function automatic res_t mk_error(logic [2:0] kind, logic [7:0] arg);
        res_t r;
        r = '0;
        r.error_kind = kind;
        r.error_arg  = arg;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sbrs_ram.sv @@
`default_nettype none

module sbrs_ram #(
    parameter int WIDTH = 59,
    parameter int DEPTH = 8
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic      [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/sbrs_out_buf.sv @@
`default_nettype none

module sbrs_out_buf
    import sbrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire logic [2:0] load_cnt,
    input  res_t      load_res [MAX_RES],
    output logic      can_load,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res,
    output logic      out_last
);
    res_t       buf_reg [MAX_RES];
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg, rd_next;
    logic       take;

    assign out_valid = (cnt_reg != 3'd0);
    assign take      = out_valid && out_ready;
    assign can_load  = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && out_ready);
    assign out_res   = buf_reg[rd_reg];
    assign out_last  = (cnt_reg == 3'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load)
        begin
            cnt_next = load_cnt;
            rd_next  = 2'd0;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 3'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            rd_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= load_res;
        end
    end

endmodule

`default_nettype wire

@@ rtl/servo_bus_refresh_scheduler.sv @@
// Servo bus refresh scheduler.
// An input is registered in the input stage; its results are then loaded into the result buffer
// once it can take them, and offered from there. One input per cycle while m_tready is high and each
// yields at most one result; more results hold the buffer, at one result transfer per cycle.
// Reset (rst_n low, asynchronous): all links down, sweep idle, queue empty, config
// back to count 0, ids 0, max_missed 3, expected model 0.
`default_nettype none
`include "servo_bus_refresh_scheduler_defines.svh"

module servo_bus_refresh_scheduler
    import sbrs_pkg::*;
#(
    parameter int SERVOS      = 8,
    parameter int QUEUE_DEPTH = 8,
    parameter int TORQUE_ADDR = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // target_id[7:0], write_addr[23:8], write_len[26:24], write_data[58:27],
    // driver_error[59], responder_id[67:60], status_byte[75:68], model_number[91:76]
    input  wire logic [95:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // send_id[7:0], send_address[23:8], send_len[26:24], send_data[58:27],
    // event_id[66:59], error_arg[74:67]
    output logic [79:0]      m_tdata,
    // send_valid[0], send_kind[3:1], event_kind[6:4], error_kind[9:7]
    output logic [9:0]       m_tuser,
    output logic             m_tlast
);
    localparam int SW = (SERVOS > 1) ? $clog2(SERVOS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [3:0]  servo_count_reg;
    logic [63:0] servo_ids_reg;
    logic [7:0]  max_missed_reg;
    logic [15:0] expected_model_reg;

    // input stage
    logic        in_valid_reg;
    logic [1:0]  in_req_reg;
    logic [91:0] in_data_reg;

    // scheduler state
    logic [SERVOS-1:0] link_reg, link_n;
    logic [SERVOS-1:0] alert_reg, alert_n;
    logic [SERVOS-1:0] ftd_reg, ftd_n;
    logic [7:0]        miss_reg [SERVOS];
    logic [7:0]        miss_n [SERVOS];
    logic              busy_reg, busy_n;
    logic              act_reg, act_n;
    logic              pend_reg, pend_n;
    logic              serv_reg, serv_n;
    logic [3:0]        idx_reg, idx_n;
    logic [2:0]        phase_reg, phase_n;
    logic [7:0]        qt_reg, qt_n;
    logic [QW-1:0]     head_reg, head_n;
    logic [FW-1:0]     fill_reg, fill_n;

    // queue storage
    logic                push_en;
    logic [QW-1:0]       tail;
    logic [ENTRY_W-1:0]  push_data;
    logic [ENTRY_W-1:0]  ram_q;
    logic [ENTRY_W-1:0]  byp_reg;
    logic                hit_reg;
    logic [ENTRY_W-1:0]  qhead;

    // results
    res_t       res [MAX_RES];
    logic [2:0] rc;
    logic       can_load;
    logic       fire;
    res_t       out_r;

    logic [3:0] eff;
    logic [FW:0] tsum;
    logic [QW:0] hinc;
    logic [QW-1:0] head_inc;

    assign fire     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    assign eff  = (servo_count_reg > 4'(SERVOS)) ? 4'(SERVOS) : servo_count_reg;
    assign tsum = (FW+1)'(head_reg) + (FW+1)'(fill_reg);
    assign tail = (tsum >= (FW+1)'(QUEUE_DEPTH)) ? QW'(tsum - (FW+1)'(QUEUE_DEPTH))
                                                 : QW'(tsum);
    assign hinc = (QW+1)'(head_reg) + (QW+1)'(1);
    assign head_inc = (hinc == (QW+1)'(QUEUE_DEPTH)) ? '0 : QW'(hinc);
    assign qhead = hit_reg ? byp_reg : ram_q;

    // pack the write request as it is kept in the queue
    always_comb
    begin
        logic [2:0]  len;
        logic [31:0] wd;
        len = (in_data_reg[26:24] > 3'd4) ? 3'd4 : in_data_reg[26:24];
        wd  = in_data_reg[58:27];
        case (len)
            3'd0:    wd = 32'd0;
            3'd1:    wd = {24'd0, wd[7:0]};
            3'd2:    wd = {16'd0, wd[15:0]};
            3'd3:    wd = {8'd0, wd[23:0]};
            default: wd = wd;
        endcase
        push_data = {wd, len, in_data_reg[23:8], in_data_reg[7:0]};
    end

    always_comb
    begin
        logic [7:0]         rid;
        logic [7:0]         st;
        logic [7:0]         cur_id;
        logic [7:0]         nid;
        logic [7:0]         m;
        logic [SW-1:0]      ci;
        logic [SW-1:0]      ti;
        logic               ok;
        logic               step;
        logic               need_trig;
        logic               need_nor;
        logic               need_trig2;
        logic               need_nor2;
        logic [ENTRY_W-1:0] e;

        link_n  = link_reg;
        alert_n = alert_reg;
        ftd_n   = ftd_reg;
        miss_n  = miss_reg;
        busy_n  = busy_reg;
        act_n   = act_reg;
        pend_n  = pend_reg;
        serv_n  = serv_reg;
        idx_n   = idx_reg;
        phase_n = phase_reg;
        qt_n    = qt_reg;
        head_n  = head_reg;
        fill_n  = fill_reg;
        push_en = 1'b0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            res[k] = '0;
        end
        rc = 3'd0;

        rid    = in_data_reg[67:60];
        st     = in_data_reg[75:68];
        ci     = idx_reg[SW-1:0];
        cur_id = servo_ids_reg[{idx_reg[2:0], 3'b000} +: 8];
        ok     = !in_data_reg[59] && (rid == cur_id) && ((st & STATUS_ERR_MASK) == 8'd0);
        m      = 8'd0;
        ti     = '0;
        nid    = 8'd0;
        step       = 1'b0;
        need_trig  = 1'b0;
        need_nor   = 1'b0;
        need_trig2 = 1'b0;
        need_nor2  = 1'b0;
        e = (fill_reg == '0) ? push_data : qhead;

        if (fire)
        begin
            case (in_req_reg)
                REQ_TICK:
                begin
                    if (act_reg || pend_reg)
                    begin
                        res[rc[1:0]] = mk_error(ER_TICK_OVERLAP, 8'd0);
                        rc = rc + 3'd1;
                    end
                    else
                    begin
                        idx_n = 4'd0;
                        if (!busy_reg)
                        begin
                            busy_n    = 1'b1;
                            act_n     = 1'b1;
                            serv_n    = 1'b0;
                            need_trig = 1'b1;
                        end
                        else
                        begin
                            pend_n = 1'b1;
                        end
                    end
                end
                REQ_WRITE:
                begin
                    if (fill_reg >= FW'(QUEUE_DEPTH))
                    begin
                        res[rc[1:0]] = mk_error(ER_QUEUE_FULL, 8'd0);
                        rc = rc + 3'd1;
                    end
                    else
                    begin
                        push_en = 1'b1;
                        fill_n  = fill_reg + FW'(1);
                        if (!busy_reg)
                        begin
                            busy_n   = 1'b1;
                            need_nor = 1'b1;
                        end
                    end
                end
                REQ_DONE:
                begin
                    if (busy_reg && serv_reg)
                    begin
                        if (in_data_reg[59])
                        begin
                            res[rc[1:0]] = mk_error(ER_XFER_FAILED, 8'd0);
                            rc = rc + 3'd1;
                        end
                        if ((st & STATUS_ERR_MASK) != 8'd0)
                        begin
                            res[rc[1:0]] = mk_error(ER_HW_ERROR, st);
                            rc = rc + 3'd1;
                        end
                        if (rid != qt_reg)
                        begin
                            res[rc[1:0]] = mk_error(ER_ID_MISMATCH, rid);
                            rc = rc + 3'd1;
                        end
                        serv_n   = 1'b0;
                        need_nor = 1'b1;
                    end
                    else if (busy_reg && act_reg)
                    begin
                        if (idx_reg >= 4'(SERVOS))
                        begin
                            step = 1'b1;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_RAM:
                                begin
                                    if (!ok)
                                    begin
                                        m = miss_reg[ci];
                                        if (m != MISS_MAX)
                                        begin
                                            m = m + 8'd1;
                                        end
                                        miss_n[ci] = m;
                                        if (m >= max_missed_reg)
                                        begin
                                            link_n[ci] = 1'b0;
                                            res[rc[1:0]] = mk_event(EV_DISCONNECTED, cur_id);
                                            rc = rc + 3'd1;
                                        end
                                    end
                                    else
                                    begin
                                        miss_n[ci] = 8'd0;
                                        res[rc[1:0]] = mk_event(EV_RAM_DONE, cur_id);
                                        rc = rc + 3'd1;
                                        if ((st & STATUS_ALERT) != 8'd0)
                                        begin
                                            if (!alert_reg[ci])
                                            begin
                                                res[rc[1:0]] = mk_event(EV_ALERT, cur_id);
                                                rc = rc + 3'd1;
                                                alert_n[ci] = 1'b1;
                                            end
                                        end
                                        else
                                        begin
                                            alert_n[ci] = 1'b0;
                                        end
                                    end
                                    step = 1'b1;
                                end
                                PH_PING:
                                begin
                                    if (!ok || in_data_reg[91:76] != expected_model_reg)
                                    begin
                                        step = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_n = PH_EEPROM;
                                        res[rc[1:0]] = mk_send(SEND_EEPROM, cur_id, 16'd0,
                                                               3'd0, 32'd0);
                                        rc = rc + 3'd1;
                                    end
                                end
                                PH_EEPROM:
                                begin
                                    if (!ok)
                                    begin
                                        step = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_n = PH_VERIFY;
                                        res[rc[1:0]] = mk_send(SEND_RAM_READ, cur_id, 16'd0,
                                                               3'd0, 32'd0);
                                        rc = rc + 3'd1;
                                    end
                                end
                                PH_VERIFY:
                                begin
                                    if (!ok)
                                    begin
                                        step = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_n = PH_TORQUE;
                                        res[rc[1:0]] = mk_send(SEND_TORQUE, cur_id,
                                                               16'(TORQUE_ADDR), 3'd1, 32'd0);
                                        rc = rc + 3'd1;
                                    end
                                end
                                PH_TORQUE:
                                begin
                                    if (ok)
                                    begin
                                        miss_n[ci] = 8'd0;
                                        link_n[ci] = 1'b1;
                                        res[rc[1:0]] = mk_event(EV_CONNECTED, cur_id);
                                        rc = rc + 3'd1;
                                    end
                                    step = 1'b1;
                                end
                                default:
                                begin
                                    step = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // finish the current servo and move on
            if (step)
            begin
                if (idx_reg < 4'(SERVOS))
                begin
                    if (!ftd_n[ci])
                    begin
                        ftd_n[ci] = 1'b1;
                        if (!link_n[ci])
                        begin
                            res[rc[1:0]] = mk_event(EV_DISCONNECTED, cur_id);
                            rc = rc + 3'd1;
                        end
                    end
                    idx_n = idx_reg + 4'd1;
                end
                need_trig = 1'b1;
            end

            if (need_trig)
            begin
                if (idx_n >= eff)
                begin
                    act_n    = 1'b0;
                    need_nor = 1'b1;
                end
                else
                begin
                    ti  = idx_n[SW-1:0];
                    nid = servo_ids_reg[{idx_n[2:0], 3'b000} +: 8];
                    if (link_n[ti])
                    begin
                        phase_n = PH_RAM;
                        res[rc[1:0]] = mk_send(SEND_RAM_READ, nid, 16'd0, 3'd0, 32'd0);
                    end
                    else
                    begin
                        phase_n = PH_PING;
                        res[rc[1:0]] = mk_send(SEND_PING, nid, 16'd0, 3'd0, 32'd0);
                    end
                    rc = rc + 3'd1;
                end
            end

            // start a pending sweep, pop a queued write, or release the bus
            if (need_nor)
            begin
                if (pend_n)
                begin
                    pend_n     = 1'b0;
                    act_n      = 1'b1;
                    serv_n     = 1'b0;
                    need_trig2 = 1'b1;
                end
                else if (fill_n != '0)
                begin
                    head_n = head_inc;
                    fill_n = fill_n - FW'(1);
                    serv_n = 1'b1;
                    qt_n   = e[7:0];
                    res[rc[1:0]] = mk_send(SEND_QUEUED, e[7:0], e[23:8], e[26:24], e[58:27]);
                    rc = rc + 3'd1;
                end
                else
                begin
                    busy_n = 1'b0;
                    serv_n = 1'b0;
                end
            end

            if (need_trig2)
            begin
                if (idx_n >= eff)
                begin
                    act_n     = 1'b0;
                    need_nor2 = 1'b1;
                end
                else
                begin
                    ti  = idx_n[SW-1:0];
                    nid = servo_ids_reg[{idx_n[2:0], 3'b000} +: 8];
                    if (link_n[ti])
                    begin
                        phase_n = PH_RAM;
                        res[rc[1:0]] = mk_send(SEND_RAM_READ, nid, 16'd0, 3'd0, 32'd0);
                    end
                    else
                    begin
                        phase_n = PH_PING;
                        res[rc[1:0]] = mk_send(SEND_PING, nid, 16'd0, 3'd0, 32'd0);
                    end
                    rc = rc + 3'd1;
                end
            end

            if (need_nor2)
            begin
                if (fill_n != '0)
                begin
                    head_n = head_inc;
                    fill_n = fill_n - FW'(1);
                    serv_n = 1'b1;
                    qt_n   = e[7:0];
                    res[rc[1:0]] = mk_send(SEND_QUEUED, e[7:0], e[23:8], e[26:24], e[58:27]);
                    rc = rc + 3'd1;
                end
                else
                begin
                    busy_n = 1'b0;
                    serv_n = 1'b0;
                end
            end
        end
    end

    sbrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (push_en),
        .waddr (tail),
        .wdata (push_data),
        .raddr (head_n),
        .rdata (ram_q)
    );

    sbrs_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .load_cnt  (rc),
        .load_res  (res),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_r),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'd0, out_r.error_arg, out_r.event_id, out_r.send_data,
                      out_r.send_len, out_r.send_address, out_r.send_id};
    assign m_tuser = {out_r.error_kind, out_r.event_kind, out_r.send_kind, out_r.send_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_count_reg    <= 4'd0;
            servo_ids_reg      <= 64'd0;
            max_missed_reg     <= 8'd3;
            expected_model_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SERVO_COUNT:    servo_count_reg    <= cfg_data[3:0];
                REG_SERVO_IDS:      servo_ids_reg      <= cfg_data;
                REG_MAX_MISSED:     max_missed_reg     <= cfg_data[7:0];
                REG_EXPECTED_MODEL: expected_model_reg <= cfg_data[15:0];
                default:            servo_count_reg    <= servo_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            link_reg     <= '0;
            alert_reg    <= '0;
            ftd_reg      <= '0;
            for (int k = 0; k < SERVOS; k++)
            begin
                miss_reg[k] <= 8'd0;
            end
            busy_reg  <= 1'b0;
            act_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            serv_reg  <= 1'b0;
            idx_reg   <= 4'd0;
            phase_reg <= PH_RAM;
            qt_reg    <= 8'd0;
            head_reg  <= '0;
            fill_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            link_reg  <= link_n;
            alert_reg <= alert_n;
            ftd_reg   <= ftd_n;
            miss_reg  <= miss_n;
            busy_reg  <= busy_n;
            act_reg   <= act_n;
            pend_reg  <= pend_n;
            serv_reg  <= serv_n;
            idx_reg   <= idx_n;
            phase_reg <= phase_n;
            qt_reg    <= qt_n;
            head_reg  <= head_n;
            fill_reg  <= fill_n;
            // a write landing on the address being read is missed by the RAM's registered read, so it is bypassed
            hit_reg   <= push_en && (tail == head_n);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg  <= s_tuser;
            in_data_reg <= s_tdata[91:0];
        end
        byp_reg <= push_data;
    end

    `SBRS_ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_reg > FW'(QUEUE_DEPTH), "queue overfilled")
    `SBRS_ASSERT_NEVER(a_sweep_excl, clk, rst_n, act_reg && pend_reg, "sweep active and pending")
    `SBRS_ASSERT_IMPLIES(a_idle_empty, clk, rst_n, !busy_reg, fill_reg == '0, "idle bus with queue")
    `SBRS_ASSERT_IMPLIES(a_sweep_busy, clk, rst_n, act_reg || serv_reg, busy_reg, "work on idle bus")

endmodule

`default_nettype wire
